>>> design/isf_pkg.sv
// ----------------------------------------------------------------------------
// Ising spin flip sweep package
// Grid size, field widths, command codes and threshold register indexes
// shared by the sweep block and its testbench.
// ----------------------------------------------------------------------------
package isf_pkg;

    localparam int SIDE      = 64;
    localparam int SITES     = SIDE * SIDE;
    localparam int ROW_W     = $clog2(SIDE);
    localparam int TOTAL_W   = $clog2(SITES) + 2;
    localparam int MAG_W     = 13;
    localparam int THR_W     = 17;
    localparam int RND_W     = 16;
    localparam int NUM_THR   = 5;
    localparam int CFG_IDX_W = 3;
    localparam int SEL_W     = 3;

    typedef logic [SIDE-1:0] t_row;

    typedef enum logic {
        CMD_INIT   = 1'b0,
        CMD_UPDATE = 1'b1
    } t_cmd;

    typedef enum logic [CFG_IDX_W-1:0] {
        THR_MINUS_FOUR = 3'd0,
        THR_MINUS_TWO  = 3'd1,
        THR_ZERO       = 3'd2,
        THR_PLUS_TWO   = 3'd3,
        THR_PLUS_FOUR  = 3'd4
    } t_thr_idx;

    // Metropolis acceptance at base 1+sqrt(2), scaled by 65536.
    localparam logic [THR_W-1:0] THR_RESET [NUM_THR] = '{
        17'd65536, 17'd65536, 17'd65536, 17'd11244, 17'd1929
    };

endpackage

>>> design/isf_ram.sv
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module isf_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]  i_wr_data,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [WIDTH-1:0]  o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> design/ising_spin_flip_sweep.sv
// ----------------------------------------------------------------------------
// Ising spin flip sweep
// One site of a toroidal +1/-1 spin grid is updated per update transfer, in
// raster order, with a threshold test on a 16-bit random number. An init
// transfer sets every spin to +1 and restarts the sweep at site (0,0).
// ----------------------------------------------------------------------------
// Every transfer, init or update, yields one registered result in the next
// cycle; a new transfer is taken in every cycle unless the result
// register is full and stalled. The rows above, at and below the current row
// live in three row registers, and the rest of the grid sits in a row memory
// that is written once at the end of each row and read two rows ahead, so the
// grid is written once per row rather than once per site. Rows never written
// since an init read back as all +1, so init is immediate and needs no
// clearing pass. abs_magnetization is nonzero only when sweep_end is set.
// ----------------------------------------------------------------------------
module ising_spin_flip_sweep (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_wr_en,
    input  logic [isf_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [isf_pkg::THR_W-1:0]   i_cfg_wdata,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic                        i_command,
    input  logic [isf_pkg::RND_W-1:0]   i_random_value,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic                        o_flipped,
    output logic                        o_new_spin,
    output logic                        o_sweep_end,
    output logic [isf_pkg::MAG_W-1:0]   o_abs_magnetization
);

    import isf_pkg::*;

    logic [THR_W-1:0]   r_thr [NUM_THR];
    logic [ROW_W-1:0]   r_row;
    logic [ROW_W-1:0]   r_col;
    logic signed [TOTAL_W-1:0] r_spin_total;
    t_row               r_prev;
    t_row               r_cur;
    t_row               r_next;
    logic [SIDE-1:0]    r_row_valid;
    logic               r_rd_valid;
    logic               r_out_valid;
    logic               r_flipped;
    logic               r_new_spin;
    logic               r_sweep_end;
    logic [MAG_W-1:0]   r_abs_mag;

    logic               w_in_fire;
    logic               w_is_init;
    logic [ROW_W-1:0]   w_col_left;
    logic [ROW_W-1:0]   w_col_right;
    logic               w_last_col;
    logic               w_last_row;
    logic               w_spin;
    logic [SEL_W-1:0]   w_agree;
    logic [THR_W-1:0]   w_thr;
    logic               w_flip;
    logic               w_new_spin;
    t_row               w_cur_flip;
    logic signed [TOTAL_W-1:0] n_spin_total;
    logic [TOTAL_W-1:0] w_abs_total;
    logic [ROW_W:0]     w_row_ahead;
    logic [ROW_W-1:0]   w_rd_addr;
    t_row               w_rd_data;
    logic               w_wr_en;

    assign o_stall   = r_out_valid && i_stall;
    assign w_in_fire = i_valid && !o_stall;
    assign w_is_init = (i_command == CMD_INIT);

    assign w_last_col  = (r_col == ROW_W'(SIDE - 1));
    assign w_last_row  = (r_row == ROW_W'(SIDE - 1));
    assign w_col_right = w_last_col ? '0 : r_col + 1'b1;
    assign w_col_left  = (r_col == '0) ? ROW_W'(SIDE - 1) : r_col - 1'b1;

    // The selected threshold is the count of neighbors that agree with the spin:
    // no agreeing neighbor is an energy term of -4, four of them +4.
    assign w_spin  = r_cur[r_col];
    assign w_agree = SEL_W'(r_prev[r_col] == w_spin)
                   + SEL_W'(r_next[r_col] == w_spin)
                   + SEL_W'(r_cur[w_col_left] == w_spin)
                   + SEL_W'(r_cur[w_col_right] == w_spin);
    assign w_thr      = r_thr[w_agree];
    assign w_flip     = {1'b0, i_random_value} < w_thr;
    assign w_new_spin = w_spin ^ w_flip;

    always_comb begin
        w_cur_flip        = r_cur;
        w_cur_flip[r_col] = w_new_spin;
    end

    always_comb begin
        n_spin_total = r_spin_total;
        if (w_flip) begin
            n_spin_total = w_spin ? r_spin_total - TOTAL_W'(2)
                                  : r_spin_total + TOTAL_W'(2);
        end
    end

    assign w_abs_total = n_spin_total[TOTAL_W-1] ? TOTAL_W'(-n_spin_total)
                                                 : TOTAL_W'(n_spin_total);

    // The row two below the current one is prefetched for the next row change.
    assign w_row_ahead = {1'b0, r_row} + (ROW_W + 1)'(2);
    assign w_rd_addr   = (w_row_ahead >= (ROW_W + 1)'(SIDE))
                       ? ROW_W'(w_row_ahead - (ROW_W + 1)'(SIDE))
                       : ROW_W'(w_row_ahead);

    assign w_wr_en = w_in_fire && !w_is_init && w_last_col;

    isf_ram #(
        .WIDTH (SIDE),
        .DEPTH (SIDE)
    ) u_row_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (r_row),
        .i_wr_data (w_cur_flip),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr        <= THR_RESET;
            r_row        <= '0;
            r_col        <= '0;
            r_spin_total <= TOTAL_W'(SITES);
            r_prev       <= '1;
            r_cur        <= '1;
            r_next       <= '1;
            r_row_valid  <= '0;
            r_rd_valid   <= 1'b0;
        end else begin
            r_rd_valid <= r_row_valid[w_rd_addr];
            if (i_cfg_wr_en && (i_cfg_index < CFG_IDX_W'(NUM_THR))) begin
                r_thr[i_cfg_index] <= i_cfg_wdata;
            end
            if (w_in_fire) begin
                if (w_is_init) begin
                    r_row        <= '0;
                    r_col        <= '0;
                    r_spin_total <= TOTAL_W'(SITES);
                    r_prev       <= '1;
                    r_cur        <= '1;
                    r_next       <= '1;
                    r_row_valid  <= '0;
                end else begin
                    r_spin_total <= n_spin_total;
                    if (w_last_col) begin
                        r_row_valid[r_row] <= 1'b1;
                        r_prev <= w_cur_flip;
                        r_cur  <= r_next;
                        r_next <= r_rd_valid ? w_rd_data : '1;
                        r_row  <= w_last_row ? '0 : r_row + 1'b1;
                        r_col  <= '0;
                    end else begin
                        r_cur <= w_cur_flip;
                        r_col <= r_col + 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_in_fire) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            if (w_is_init) begin
                r_flipped   <= 1'b0;
                r_new_spin  <= 1'b1;
                r_sweep_end <= 1'b1;
                r_abs_mag   <= MAG_W'(SITES);
            end else begin
                r_flipped   <= w_flip;
                r_new_spin  <= w_new_spin;
                r_sweep_end <= w_last_col && w_last_row;
                r_abs_mag   <= (w_last_col && w_last_row) ? MAG_W'(w_abs_total) : '0;
            end
        end
    end

    assign o_valid             = r_out_valid;
    assign o_flipped           = r_flipped;
    assign o_new_spin          = r_new_spin;
    assign o_sweep_end         = r_sweep_end;
    assign o_abs_magnetization = r_abs_mag;

    // An init transfer restarts the sweep and forgets every stored row.
    a_init_restart : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_fire && w_is_init |=> r_row == '0 && r_col == '0 &&
            r_spin_total == TOTAL_W'(SITES) && r_row_valid == '0)
        else $error("init transfer did not restart the sweep");

    // Each flip moves the total by two, so its parity never changes.
    a_total_parity : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_spin_total[0] == 1'(SITES % 2))
        else $error("spin total parity broken");

    a_mag_only_at_end : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_sweep_end |-> o_abs_magnetization == '0)
        else $error("magnetization reported away from sweep end");

    // The grid write happens only while leaving the last column of a row.
    a_row_write : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_wr_en |=> r_col == '0 && r_row_valid[$past(r_row)])
        else $error("row write without a row change");

endmodule

>>> tb/sv/tb.sv
// ----------------------------------------------------------------------------
// Ising spin flip sweep testbench
// Drives init and update transfers into the sweep block. Both channels idle
// and stall at random. A shadow copy of the spin grid, the sweep position and
// the flip thresholds predicts every result, and each result is checked
// field by field. Phases cover the reset thresholds, heat-bath thresholds,
// always-flip and never-flip settings and random extremes. The runs stay
// within the first rows of a sweep, so sweep ends come from init transfers.
// ----------------------------------------------------------------------------
import isf_pkg::*;

typedef struct packed {
    logic             flipped;
    logic             new_spin;
    logic             sweep_end;
    logic [MAG_W-1:0] magnitude;
} t_site_outcome;

class spin_grid_shadow;
    bit [SITES-1:0]                spins;
    int                            row;
    int                            col;
    int                            total;
    logic [NUM_THR-1:0][THR_W-1:0] thr;
    t_site_outcome                 pending_sites[$];
    int                            transfers;
    int                            inits;
    int                            flips;
    int                            sweep_ends;
    int                            loads;
    int                            mismatches;

    function new();
        thr[THR_MINUS_FOUR] = 17'd65536;
        thr[THR_MINUS_TWO]  = 17'd65536;
        thr[THR_ZERO]       = 17'd65536;
        thr[THR_PLUS_TWO]   = 17'd11244;
        thr[THR_PLUS_FOUR]  = 17'd1929;
        clear_grid();
    endfunction

    function void clear_grid();
        spins = '1;
        row   = 0;
        col   = 0;
        total = SITES;
    endfunction

    function int spin_of(int r, int c);
        return spins[r * SIDE + c] ? 1 : -1;
    endfunction

    // Writes past the last threshold register are dropped by the block.
    function void load_threshold(int idx, logic [THR_W-1:0] value);
        if (idx < NUM_THR) begin
            thr[idx] = value;
            loads++;
        end
    endfunction

    function void take_transfer(t_cmd cmd, logic [RND_W-1:0] rnd);
        t_site_outcome want;
        int            here;
        int            s;
        int            energy;
        t_thr_idx      sel;
        transfers++;
        if (cmd == CMD_INIT) begin
            inits++;
            clear_grid();
            want.flipped   = 1'b0;
            want.new_spin  = 1'b1;
            want.sweep_end = 1'b1;
            want.magnitude = MAG_W'(SITES);
        end else begin
            here   = row * SIDE + col;
            s      = spins[here] ? 1 : -1;
            energy = s * (spin_of((row + 1) % SIDE, col)
                        + spin_of((row + SIDE - 1) % SIDE, col)
                        + spin_of(row, (col + 1) % SIDE)
                        + spin_of(row, (col + SIDE - 1) % SIDE));
            case (energy)
                -4:      sel = THR_MINUS_FOUR;
                -2:      sel = THR_MINUS_TWO;
                0:       sel = THR_ZERO;
                2:       sel = THR_PLUS_TWO;
                default: sel = THR_PLUS_FOUR;
            endcase
            want.flipped = ({1'b0, rnd} < thr[sel]);
            if (want.flipped) begin
                spins[here] = ~spins[here];
                total -= 2 * s;
                flips++;
            end
            want.new_spin  = spins[here];
            want.sweep_end = (row == SIDE - 1) && (col == SIDE - 1);
            want.magnitude = '0;
            if (want.sweep_end) begin
                sweep_ends++;
                want.magnitude = MAG_W'(total < 0 ? -total : total);
            end
            if (col == SIDE - 1) begin
                col = 0;
                row = (row == SIDE - 1) ? 0 : row + 1;
            end else begin
                col++;
            end
        end
        pending_sites.push_back(want);
    endfunction

    function void check_site(logic flipped, logic new_spin, logic sweep_end,
                             logic [MAG_W-1:0] magnitude);
        t_site_outcome want;
        if (pending_sites.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("%0t: result with no transfer outstanding", $time);
            return;
        end
        want = pending_sites.pop_front();
        if (flipped !== want.flipped || new_spin !== want.new_spin
                || sweep_end !== want.sweep_end || magnitude !== want.magnitude) begin
            mismatches++;
            if (mismatches <= 10)
                $display({"%0t: mismatch, expected flipped=%0d spin=%0d end=%0d mag=%0d,",
                          " got flipped=%0d spin=%0d end=%0d mag=%0d"},
                         $time, want.flipped, want.new_spin, want.sweep_end,
                         want.magnitude, flipped, new_spin, sweep_end, magnitude);
        end
    endfunction

    function int failures();
        return mismatches + pending_sites.size();
    endfunction
endclass

module tb;

    localparam int SETTLE_CYCLES  = 4;
    localparam int WATCHDOG_LIMIT = 1000;

    logic                 i_clk               = 1'b0;
    logic                 i_rst_n             = 1'b0;
    logic                 i_cfg_wr_en         = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index         = '0;
    logic [THR_W-1:0]     i_cfg_wdata         = '0;
    logic                 i_valid             = 1'b0;
    logic                 o_stall;
    logic                 i_command           = 1'b1;
    logic [RND_W-1:0]     i_random_value      = '0;
    logic                 o_valid;
    logic                 i_stall             = 1'b0;
    logic                 o_flipped;
    logic                 o_new_spin;
    logic                 o_sweep_end;
    logic [MAG_W-1:0]     o_abs_magnetization;

    spin_grid_shadow shadow = new();
    bit              steady = 1'b0;
    int              quiet_cycles = 0;
    int              settings = 1;

    ising_spin_flip_sweep dut (.*);

    always #5 i_clk = ~i_clk;

    // Mostly no gap, some short ones and now and then a long one.
    function automatic int idle_length();
        int roll;
        roll = $urandom_range(99);
        if (steady) return 0;
        if (roll < 60) return 0;
        if (roll < 90) return $urandom_range(1, 3);
        if (roll < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [THR_W-1:0] extreme_threshold();
        case ($urandom_range(7))
            0:       return '0;
            1:       return 17'd65536;
            2:       return 17'd65535;
            3:       return 17'd1;
            default: return THR_W'($urandom_range(0, 65536));
        endcase
    endfunction

    task automatic send_transfer(t_cmd cmd, logic [RND_W-1:0] rnd);
        int gap;
        gap = idle_length();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_command      <= cmd;
        i_random_value <= rnd;
        do @(posedge i_clk); while (o_stall);
    endtask

    // One init in about init_odds transfers; zero gives none.
    task automatic run_updates(int count, int init_odds);
        t_cmd cmd;
        repeat (count) begin
            cmd = CMD_UPDATE;
            if (init_odds > 0 && $urandom_range(init_odds - 1) == 0)
                cmd = CMD_INIT;
            send_transfer(cmd, RND_W'($urandom));
        end
    endtask

    task automatic settle();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (shadow.pending_sites.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // The write after the last register goes to an unused index.
    task automatic write_thresholds(logic [THR_W-1:0] m4, logic [THR_W-1:0] m2,
                                    logic [THR_W-1:0] z, logic [THR_W-1:0] p2,
                                    logic [THR_W-1:0] p4);
        logic [NUM_THR-1:0][THR_W-1:0] plan;
        logic [THR_W-1:0]              data;
        plan[THR_MINUS_FOUR] = m4;
        plan[THR_MINUS_TWO]  = m2;
        plan[THR_ZERO]       = z;
        plan[THR_PLUS_TWO]   = p2;
        plan[THR_PLUS_FOUR]  = p4;
        for (int i = 0; i <= NUM_THR; i++) begin
            data         = (i < NUM_THR) ? plan[i] : THR_W'($urandom);
            i_cfg_wr_en <= 1'b1;
            i_cfg_index <= CFG_IDX_W'(i);
            i_cfg_wdata <= data;
            @(posedge i_clk);
            shadow.load_threshold(i, data);
        end
        i_cfg_wr_en <= 1'b0;
        settings++;
    endtask

    initial begin : receiver_stall
        int hold;
        forever begin
            i_stall <= 1'b0;
            repeat (idle_length() + 1) @(posedge i_clk);
            hold = idle_length();
            if (hold > 0) begin
                i_stall <= 1'b1;
                repeat (hold) @(posedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && !o_stall)
                shadow.take_transfer(t_cmd'(i_command), i_random_value);
            if (o_valid && !i_stall)
                shadow.check_site(o_flipped, o_new_spin, o_sweep_end, o_abs_magnetization);
            if ((i_valid && !o_stall) || (o_valid && !i_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("Watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
                $display("FAIL");
                $finish;
            end
        end
    end

    initial begin : stimulus
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset thresholds: fixed values on both sides of the +4 and +2 limits.
        send_transfer(CMD_UPDATE, 16'd1929);
        send_transfer(CMD_UPDATE, 16'd1928);
        send_transfer(CMD_UPDATE, 16'd11244);
        send_transfer(CMD_UPDATE, 16'd0);
        send_transfer(CMD_UPDATE, 16'd11243);
        send_transfer(CMD_UPDATE, 16'hFFFF);
        send_transfer(CMD_INIT, 16'hFFFF);
        send_transfer(CMD_INIT, 16'd0);
        send_transfer(CMD_UPDATE, 16'd0);
        send_transfer(CMD_UPDATE, 16'd0);
        send_transfer(CMD_UPDATE, 16'h5555);
        send_transfer(CMD_UPDATE, 16'hAAAA);
        send_transfer(CMD_UPDATE, 16'h8000);
        send_transfer(CMD_UPDATE, 16'd1);
        send_transfer(CMD_INIT, 16'h5555);
        send_transfer(CMD_UPDATE, 16'hFFFF);
        settle();

        write_thresholds(17'd63662, 17'd55939, 17'd32768, 17'd9598, 17'd1874);
        run_updates(600, 150);
        settle();

        // Every site flips, over several row changes with no idling on either side.
        write_thresholds(17'd65536, 17'd65536, 17'd65536, 17'd65536, 17'd65536);
        steady = 1'b1;
        send_transfer(CMD_INIT, RND_W'($urandom));
        send_transfer(CMD_UPDATE, 16'hFFFF);
        run_updates(200, 0);
        settle();
        steady = 1'b0;

        write_thresholds('0, '0, '0, '0, '0);
        send_transfer(CMD_UPDATE, 16'd0);
        run_updates(250, 0);
        settle();

        write_thresholds(extreme_threshold(), extreme_threshold(), extreme_threshold(),
                         extreme_threshold(), extreme_threshold());
        run_updates(300, 100);
        settle();

        // Init after rows of flipped spins, then heat-bath updates over a few rows.
        write_thresholds(17'd63662, 17'd55939, 17'd32768, 17'd9598, 17'd1874);
        send_transfer(CMD_INIT, RND_W'($urandom));
        run_updates(200, 0);
        settle();

        write_thresholds(extreme_threshold(), extreme_threshold(), extreme_threshold(),
                         extreme_threshold(), extreme_threshold());
        run_updates(280, 60);
        settle();

        $display("Covered %0d transfers (%0d grid inits), %0d spin flips, %0d update sweep ends.",
                 shadow.transfers, shadow.inits, shadow.flips, shadow.sweep_ends);
        $display("Thresholds loaded %0d times over %0d settings; %0d mismatches.",
                 shadow.loads, settings, shadow.failures());
        if (shadow.failures() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
